>>> hdl/msr_pkg.sv
// Shared types and constants for the MPEG video stuffing remover.
// No dependencies; used by every module in the hdl folder.
`default_nettype none
package msr_pkg;

    localparam logic [31:0] SC_MASK    = 32'hffff_ff00;
    localparam logic [31:0] SC_PREFIX  = 32'h0000_0100;
    localparam logic [31:0] ZERO_RUN   = 32'h0000_0000;

    localparam logic [7:0]  CODE_SEQ_HDR  = 8'hB3;
    localparam logic [7:0]  CODE_SEQ_EXT  = 8'hB5;
    localparam logic [7:0]  CODE_SLICE_LO = 8'h01;
    localparam logic [7:0]  CODE_SLICE_HI = 8'hAF;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // One accepted byte that causes results: the window and how to walk it.
    typedef struct packed {
        logic [31:0] win;         // window after the new byte went in
        logic [1:0]  start;       // byte position of the first result
        logic [1:0]  cnt_m1;      // number of results minus one
        logic        first;       // first result is the byte pushed out of a full window
        logic        keep_first;
        logic        keep_rest;
        logic        copy;
        logic        last;        // entry closes the frame
        logic        hdr_found;
    } msr_entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } msr_qstat_t;

endpackage
`default_nettype wire

>>> hdl/mpeg_video_stuffing_remover.sv
// Top level of the MPEG video stuffing remover: front end, queue, back end.
// Depends on msr_pkg, msr_front, msr_queue and msr_back.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+------------------------------------------
//  in       | in        | in_valid / in_ready   | data_byte, frame_last
//  out      | out       | out_valid / out_ready | out_byte, keep_in_frame, header_copy,
//           |           |                      | frame_end, header_found, run_last
//  cfg      | in        | cfg_valid / cfg_ready | cfg_data (header_out_of_frame)
//
// One byte accepted per cycle while the queue is not full. Once a frame's window holds four
// bytes, each accepted byte pushes out its oldest byte, which reaches the output through the
// queue and the output register. A frame's last byte gives up to four results, one per cycle
// from the output sequencer while out_ready is high; the four-entry queue absorbs them.
// in_ready drops only when the queue is full. cfg_ready is always high.
// Reset is asynchronous, active low, and clears all frame state and the queue.
`default_nettype none
module mpeg_video_stuffing_remover
    import msr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic       frame_last,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            keep_in_frame,
    output logic            header_copy,
    output logic            frame_end,
    output logic            header_found,
    output logic            run_last,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_data
);

    logic       hdr_out_reg;
    logic       q_push, q_pop;
    msr_entry_t q_entry, q_head;
    msr_qstat_t q_stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hdr_out_reg <= 1'b0;
        else if (cfg_valid && cfg_ready)
            hdr_out_reg <= cfg_data;
    end

    msr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .frame_last (frame_last),
        .hdr_out    (hdr_out_reg),
        .q_stat     (q_stat),
        .q_push     (q_push),
        .q_entry    (q_entry)
    );

    msr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .stat       (q_stat)
    );

    msr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (q_head),
        .q_stat        (q_stat),
        .pop           (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .keep_in_frame (keep_in_frame),
        .header_copy   (header_copy),
        .frame_end     (frame_end),
        .header_found  (header_found),
        .run_last      (run_last)
    );

    // the frame end is always the final result of its transaction
    a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> run_last)
        else $error("frame_end without run_last");

    a_found_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && header_found |-> frame_end)
        else $error("header_found away from frame end");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_stat.full))
        else $error("queue push while full");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("queue pop while empty");

endmodule
`default_nettype wire

>>> hdl/msr_front.sv
// Front end: byte window, start code classification and frame state.
// Depends on msr_pkg; feeds msr_queue with one entry per byte that causes results.
`default_nettype none
module msr_front
    import msr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic       frame_last,
    input  wire logic       hdr_out,
    input  msr_qstat_t      q_stat,
    output logic            q_push,
    output msr_entry_t      q_entry
);

    logic [31:0] win_reg, win_next;
    logic [1:0]  fill_reg, fill_next;
    logic [7:0]  code_reg, code_next;
    logic        chunk_valid_reg, chunk_valid_next;
    logic        stuff_reg, stuff_next;
    logic        hdr_seen_reg, hdr_seen_next;
    logic        copy_reg, copy_next;

    logic [31:0] win_shift;
    logic        accept, full4, is_sc, in_slice, open_stuff;
    logic        stuff_mid, hdr_seen_mid, copy_mid, drop_hdr;
    logic [7:0]  new_code;

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        win_shift    = {win_reg[23:0], data_byte};
        new_code     = win_shift[7:0];
        full4        = (fill_reg == 2'd3);
        is_sc        = full4 && ((win_shift & SC_MASK) == SC_PREFIX);
        in_slice     = chunk_valid_reg && (code_reg >= CODE_SLICE_LO)
                       && (code_reg <= CODE_SLICE_HI);
        open_stuff   = full4 && !is_sc && in_slice && !stuff_reg && (win_shift == ZERO_RUN);
        stuff_mid    = is_sc ? 1'b0 : stuff_reg;
        hdr_seen_mid = hdr_seen_reg || (is_sc && (new_code == CODE_SEQ_HDR));
        copy_mid     = is_sc ? ((new_code == CODE_SEQ_HDR)
                                || ((new_code == CODE_SEQ_EXT) && hdr_seen_mid))
                             : copy_reg;
        drop_hdr     = copy_mid && hdr_out;

        q_entry.win        = win_shift;
        q_entry.start      = full4 ? 2'd3 : fill_reg;
        q_entry.cnt_m1     = full4 ? (frame_last ? 2'd3 : 2'd0) : fill_reg;
        q_entry.first      = full4;
        q_entry.keep_first = !stuff_mid && !drop_hdr;
        q_entry.keep_rest  = !(stuff_mid || open_stuff) && !drop_hdr;
        q_entry.copy       = copy_mid;
        q_entry.last       = frame_last;
        q_entry.hdr_found  = hdr_seen_mid;

        q_push = accept && (full4 || frame_last);

        win_next         = win_reg;
        fill_next        = fill_reg;
        code_next        = code_reg;
        chunk_valid_next = chunk_valid_reg;
        stuff_next       = stuff_reg;
        hdr_seen_next    = hdr_seen_reg;
        copy_next        = copy_reg;
        if (accept)
        begin
            if (frame_last)
            begin
                // flush: clear all frame state
                win_next         = '0;
                fill_next        = '0;
                code_next        = '0;
                chunk_valid_next = 1'b0;
                stuff_next       = 1'b0;
                hdr_seen_next    = 1'b0;
                copy_next        = 1'b0;
            end
            else
            begin
                win_next      = win_shift;
                fill_next     = full4 ? 2'd3 : fill_reg + 2'd1;
                stuff_next    = stuff_mid || open_stuff;
                hdr_seen_next = hdr_seen_mid;
                copy_next     = copy_mid;
                if (is_sc)
                begin
                    code_next        = new_code;
                    chunk_valid_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg         <= '0;
            fill_reg        <= '0;
            code_reg        <= '0;
            chunk_valid_reg <= 1'b0;
            stuff_reg       <= 1'b0;
            hdr_seen_reg    <= 1'b0;
            copy_reg        <= 1'b0;
        end
        else
        begin
            win_reg         <= win_next;
            fill_reg        <= fill_next;
            code_reg        <= code_next;
            chunk_valid_reg <= chunk_valid_next;
            stuff_reg       <= stuff_next;
            hdr_seen_reg    <= hdr_seen_next;
            copy_reg        <= copy_next;
        end
    end

endmodule
`default_nettype wire

>>> hdl/msr_queue.sv
// Short entry queue between the front end and the output sequencer.
// Depends on msr_pkg for the entry type and depth.
`default_nettype none
module msr_queue
    import msr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  msr_entry_t push_entry,
    input  wire logic pop,
    output msr_entry_t head,
    output msr_qstat_t stat
);

    msr_entry_t mem [QDEPTH];

    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign head       = mem[rd_ptr_reg];

    always_comb
    begin
        do_push     = push && !stat.full;
        do_pop      = pop && !stat.empty;
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + QCNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

>>> hdl/msr_back.sv
// Back end: walks each queued entry into the output register, one byte per cycle unless out_ready stalls it.
// Depends on msr_pkg; pops msr_queue after the entry's last byte.
`default_nettype none
module msr_back
    import msr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  msr_entry_t      head,
    input  msr_qstat_t      q_stat,
    output logic            pop,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            keep_in_frame,
    output logic            header_copy,
    output logic            frame_end,
    output logic            header_found,
    output logic            run_last
);

    logic [1:0] k_reg, k_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] byte_reg;
    logic       keep_reg, copy_reg, end_reg, found_reg, run_last_reg;

    logic       advance, at_last;
    logic [1:0] pos;
    logic [7:0] sel_byte;

    always_comb
    begin
        advance  = !q_stat.empty && (!out_valid_reg || out_ready);
        at_last  = (k_reg == head.cnt_m1);
        pos      = head.start - k_reg;
        sel_byte = head.win[{pos, 3'b000} +: 8];
        pop      = advance && at_last;

        k_next = k_reg;
        if (advance)
            k_next = at_last ? 2'd0 : k_reg + 2'd1;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            byte_reg     <= sel_byte;
            keep_reg     <= (head.first && (k_reg == 2'd0)) ? head.keep_first : head.keep_rest;
            copy_reg     <= head.copy;
            end_reg      <= head.last && at_last;
            found_reg    <= head.last && at_last && head.hdr_found;
            run_last_reg <= at_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = byte_reg;
    assign keep_in_frame = keep_reg;
    assign header_copy   = copy_reg;
    assign frame_end     = end_reg;
    assign header_found  = found_reg;
    assign run_last      = run_last_reg;

endmodule
`default_nettype wire
